@@ design/bbf_pkg.sv @@
// ----------------------------------------------------------------------------
// bbf_pkg: shared types and constants for the blocked Bloom filter
// Sizes of the block store, request and config codes, the front-to-back
// work item and the configuration register set.
// ----------------------------------------------------------------------------
`default_nettype none

package bbf_pkg;

  localparam int MAX_BLOCKS_LOG2 = 12;
  localparam int BLK_W           = MAX_BLOCKS_LOG2;
  localparam int DEPTH           = 1 << MAX_BLOCKS_LOG2;
  localparam int WORDS           = 4;
  localparam int WORD_W          = 32;
  localparam int BLOCK_W         = WORDS * WORD_W;
  localparam int SEL_W           = 2;
  localparam int POS_W           = 5;
  localparam int HASH_W          = 64;
  localparam int SHIFT_W         = 7;
  localparam int WIDX_W          = 14;
  localparam int REQ_W           = 2;
  localparam int LOG2_W          = 4;
  localparam int COUNT_W         = 20;
  localparam int INC_W           = 6;
  localparam int CFG_IDX_W       = 3;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FIND  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_MERGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_LOG2 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SALT_0      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SALT_1      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SALT_2      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SALT_3      = 3'd4;

  localparam logic [LOG2_W-1:0] BLOCKS_LOG2_RESET = 4'd12;
  localparam logic [WORDS-1:0][WORD_W-1:0] SALT_RESET = {
    32'd2729912477, 32'd2284105051, 32'd1150766481, 32'd1203114875
  };

  typedef enum logic [1:0] {
    OP_ADD,
    OP_FIND,
    OP_MERGE,
    OP_NONE
  } op_t;

  typedef struct packed {
    logic [LOG2_W-1:0]             blocks_log2;
    logic [WORDS-1:0][WORD_W-1:0]  salt;
  } cfg_t;

  typedef struct packed {
    op_t                           op;
    logic [BLK_W-1:0]              blk;
    logic [WORDS-1:0][WORD_W-1:0]  mask;
    logic [SEL_W-1:0]              sel;
    logic                          error;
  } work_t;

endpackage

`default_nettype wire

@@ design/bbf_req_if.sv @@
// ----------------------------------------------------------------------------
// bbf_req_if: request channel
// Valid/ready channel carrying one filter request item.
// ----------------------------------------------------------------------------
`default_nettype none

interface bbf_req_if;
  logic                           valid;
  logic                           ready;
  logic [bbf_pkg::REQ_W-1:0]      req_type;
  logic [bbf_pkg::HASH_W-1:0]     key_hash;
  logic [bbf_pkg::WIDX_W-1:0]     word_index;
  logic [bbf_pkg::WORD_W-1:0]     word_value;

  modport source (output valid, req_type, key_hash, word_index, word_value, input ready);
  modport sink   (input valid, req_type, key_hash, word_index, word_value, output ready);
endinterface

`default_nettype wire

@@ design/bbf_res_if.sv @@
// ----------------------------------------------------------------------------
// bbf_res_if: result channel
// Valid/ready channel carrying one result item per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface bbf_res_if;
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic [bbf_pkg::COUNT_W-1:0]    set_bits;
  logic                           error;

  modport source (output valid, found, set_bits, error, input ready);
  modport sink   (input valid, found, set_bits, error, output ready);
endinterface

`default_nettype wire

@@ design/bbf_cfg_if.sv @@
// ----------------------------------------------------------------------------
// bbf_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface bbf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bbf_pkg::CFG_IDX_W-1:0]  index;
  logic [bbf_pkg::WORD_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ design/bbf_front.sv @@
// ----------------------------------------------------------------------------
// bbf_front: request classifier
// Registers the salted products and block pick of each request, then decodes
// them into a work item (block address and 128-bit mask) for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bbf_front (
  input  logic                clk,
  input  logic                rst,
  input  bbf_pkg::cfg_t       regs,
  input  logic                enable,
  bbf_req_if.sink             req,
  output bbf_pkg::work_t      push_data,
  output logic                push_valid,
  input  logic                push_ready
);

  logic                                 s1_valid;
  bbf_pkg::op_t                         s1_op;
  logic [bbf_pkg::BLK_W-1:0]            s1_blk;
  logic [bbf_pkg::POS_W-1:0]            s1_pos [bbf_pkg::WORDS];
  logic [bbf_pkg::WORD_W-1:0]           s1_value;
  logic [bbf_pkg::SEL_W-1:0]            s1_sel;
  logic                                 s1_error;

  logic [bbf_pkg::WORD_W-1:0]           prod [bbf_pkg::WORDS];
  logic [bbf_pkg::LOG2_W-1:0]           used_log2;
  logic [bbf_pkg::SHIFT_W-1:0]          shamt;
  logic [31:0]                          limit;
  logic                                 in_range;
  bbf_pkg::op_t                         in_op;
  logic                                 in_error;
  logic [bbf_pkg::BLK_W-1:0]            in_blk;
  logic                                 accept;

  assign req.ready = enable && (!s1_valid || push_ready);
  assign accept    = req.valid && req.ready;

  always_comb begin
    for (int w = 0; w < bbf_pkg::WORDS; w++) begin
      prod[w] = req.key_hash[bbf_pkg::WORD_W-1:0] * regs.salt[w];
    end
  end

  always_comb begin
    // clamp to the store size
    if (32'(regs.blocks_log2) > 32'(bbf_pkg::MAX_BLOCKS_LOG2)) begin
      used_log2 = bbf_pkg::LOG2_W'(bbf_pkg::MAX_BLOCKS_LOG2);
    end else begin
      used_log2 = regs.blocks_log2;
    end
    shamt    = bbf_pkg::SHIFT_W'(bbf_pkg::HASH_W) - bbf_pkg::SHIFT_W'(used_log2);
    limit    = 32'(bbf_pkg::WORDS) << used_log2;
    in_range = 32'(req.word_index) < limit;
    in_error = 1'b0;
    in_blk   = bbf_pkg::BLK_W'(req.key_hash >> shamt);
    unique case (req.req_type)
      bbf_pkg::REQ_ADD:  in_op = bbf_pkg::OP_ADD;
      bbf_pkg::REQ_FIND: in_op = bbf_pkg::OP_FIND;
      bbf_pkg::REQ_MERGE: begin
        in_blk   = bbf_pkg::BLK_W'(32'(req.word_index) >> bbf_pkg::SEL_W);
        in_op    = in_range ? bbf_pkg::OP_MERGE : bbf_pkg::OP_NONE;
        in_error = !in_range;
      end
      default: in_op = bbf_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (push_ready) begin
        s1_valid <= 1'b0;
      end
    end
    if (accept) begin
      s1_op    <= in_op;
      s1_blk   <= in_blk;
      s1_value <= req.word_value;
      s1_sel   <= req.word_index[bbf_pkg::SEL_W-1:0];
      s1_error <= in_error;
      for (int w = 0; w < bbf_pkg::WORDS; w++) begin
        s1_pos[w] <= prod[w][bbf_pkg::WORD_W-1 -: bbf_pkg::POS_W];
      end
    end
  end

  always_comb begin
    push_data.op    = s1_op;
    push_data.blk   = s1_blk;
    push_data.sel   = s1_sel;
    push_data.error = s1_error;
    for (int w = 0; w < bbf_pkg::WORDS; w++) begin
      if (s1_op == bbf_pkg::OP_MERGE) begin
        push_data.mask[w] = (s1_sel == bbf_pkg::SEL_W'(w)) ? s1_value : '0;
      end else begin
        push_data.mask[w] = bbf_pkg::WORD_W'(1) << s1_pos[w];
      end
    end
  end

  assign push_valid = s1_valid;

endmodule

`default_nettype wire

@@ design/bbf_queue.sv @@
// ----------------------------------------------------------------------------
// bbf_queue: work queue
// Short FIFO of classified work items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module bbf_queue (
  input  logic                clk,
  input  logic                rst,
  input  bbf_pkg::work_t      push_data,
  input  logic                push_valid,
  output logic                push_ready,
  output bbf_pkg::work_t      pop_data,
  output logic                pop_valid,
  input  logic                pop_ready
);

  bbf_pkg::work_t                 entries [bbf_pkg::QUEUE_DEPTH];
  logic [bbf_pkg::QPTR_W-1:0]     wr_ptr;
  logic [bbf_pkg::QPTR_W-1:0]     rd_ptr;
  logic [bbf_pkg::QPTR_W:0]       fill;
  logic                           push;
  logic                           pop;

  assign push_ready = fill != (bbf_pkg::QPTR_W+1)'(bbf_pkg::QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ design/bbf_back.sv @@
// ----------------------------------------------------------------------------
// bbf_back: block store engine
// Holds the block memory and the set-bit count. Clears the memory after
// reset, then reads the picked block for each work item, writes it back for
// adds and merges, and loads the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bbf_back (
  input  logic                clk,
  input  logic                rst,
  input  bbf_pkg::work_t      pop_data,
  input  logic                pop_valid,
  output logic                pop_ready,
  bbf_res_if.source           res,
  output logic                clearing
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD
  } state_t;

  state_t                               state;
  logic [bbf_pkg::BLOCK_W-1:0]          mem [bbf_pkg::DEPTH];
  logic [bbf_pkg::BLOCK_W-1:0]          rd_data;
  logic [bbf_pkg::BLK_W-1:0]            clr_addr;
  bbf_pkg::work_t                       cur;
  logic [bbf_pkg::COUNT_W-1:0]          count;
  logic [bbf_pkg::COUNT_W-1:0]          count_next;

  logic                                 out_free;
  logic                                 take;
  logic                                 res_load;
  logic                                 mem_we;
  logic [bbf_pkg::BLK_W-1:0]            mem_wa;
  logic [bbf_pkg::BLOCK_W-1:0]          mem_wd;
  logic [bbf_pkg::WORDS-1:0][bbf_pkg::WORD_W-1:0] old_words;
  logic [bbf_pkg::WORDS-1:0][bbf_pkg::WORD_W-1:0] fresh;
  logic [bbf_pkg::WORDS-1:0]            word_new;
  logic [bbf_pkg::INC_W-1:0]            inc;
  logic [bbf_pkg::COUNT_W:0]            sum;
  logic                                 hit;

  assign clearing  = state == S_CLEAR;
  assign out_free  = !res.valid || res.ready;
  assign pop_ready = (state == S_IDLE) && out_free;
  assign take      = pop_valid && pop_ready;
  assign res_load  = (state == S_MOD) || (take && (pop_data.op == bbf_pkg::OP_NONE));

  assign old_words = rd_data;

  always_comb begin
    fresh = cur.mask & ~old_words;
    for (int w = 0; w < bbf_pkg::WORDS; w++) begin
      word_new[w] = |fresh[w];
    end
    // an add sets at most one bit per word; a merge touches one word
    if (cur.op == bbf_pkg::OP_MERGE) begin
      inc = bbf_pkg::INC_W'($countones(fresh[cur.sel]));
    end else if (cur.op == bbf_pkg::OP_ADD) begin
      inc = bbf_pkg::INC_W'($countones(word_new));
    end else begin
      // a find leaves the store as it is
      inc = '0;
    end
    sum = {1'b0, count} + (bbf_pkg::COUNT_W+1)'(inc);
    if (sum[bbf_pkg::COUNT_W]) begin
      count_next = bbf_pkg::COUNT_MAX;
    end else begin
      count_next = sum[bbf_pkg::COUNT_W-1:0];
    end
    hit = (cur.op == bbf_pkg::OP_FIND) && ((old_words & cur.mask) == cur.mask);
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = cur.blk;
    mem_wd = old_words | cur.mask;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_addr;
      mem_wd = '0;
    end else if (state == S_MOD) begin
      mem_we = (cur.op == bbf_pkg::OP_ADD) || (cur.op == bbf_pkg::OP_MERGE);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (take) begin
      rd_data <= mem[pop_data.blk];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      count     <= '0;
      res.valid <= 1'b0;
    end else begin
      if (res_load) begin
        res.valid <= 1'b1;
      end else if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == bbf_pkg::BLK_W'(bbf_pkg::DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (take) begin
            cur <= pop_data;
            if (pop_data.op == bbf_pkg::OP_NONE) begin
              res.found    <= 1'b0;
              res.error    <= pop_data.error;
              res.set_bits <= count;
            end else begin
              state <= S_MOD;
            end
          end
        end
        S_MOD: begin
          count        <= count_next;
          res.found    <= hit;
          res.error    <= 1'b0;
          res.set_bits <= count_next;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !res.valid && !pop_ready)
    else $error("result or pop during clearing pass");

  a_mod_slot_free: assert property (@(posedge clk) disable iff (rst)
    state == S_MOD |-> !res.valid)
    else $error("result register occupied while an item is in flight");

  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> count >= $past(count))
    else $error("set-bit count decreased");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(state) == S_IDLE || $past(state) == S_MOD)
    else $error("result raised from an unexpected state");

endmodule

`default_nettype wire

@@ design/blocked_bloom_filter_128bit_core.sv @@
// ----------------------------------------------------------------------------
// blocked_bloom_filter_128bit_core: blocked Bloom filter, 4 x 32-bit blocks
// Add, find and merge over a 4096-block store with a running set-bit count.
//
//   channel  dir  payload                                      handshake
//   req      in   req_type, key_hash, word_index, word_value   valid/ready
//   res      out  found, set_bits, error                       valid/ready
//   cfg      in   index, data                                  valid/ready
//
// Add, find and merge hold the store engine for a take and block read in
// S_IDLE, then an update and result load in S_MOD; out-of-range merges and
// unused codes load their result at the take. A req item passes the front
// register and the queue before the engine takes it.
// After reset a clearing pass zeroes all 4096 blocks of the store, one block
// a cycle; req is not ready during it, cfg writes are taken throughout.
// A stalled res holds its item; the engine stops taking work until it moves.
// ----------------------------------------------------------------------------
`default_nettype none

module blocked_bloom_filter_128bit_core (
  input  logic        clk,
  input  logic        rst,
  bbf_req_if.sink     req,
  bbf_res_if.source   res,
  bbf_cfg_if.sink     cfg
);

  bbf_pkg::cfg_t      regs;
  bbf_pkg::work_t     push_data;
  bbf_pkg::work_t     pop_data;
  logic               push_valid;
  logic               push_ready;
  logic               pop_valid;
  logic               pop_ready;
  logic               clearing;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.blocks_log2 <= bbf_pkg::BLOCKS_LOG2_RESET;
      regs.salt        <= bbf_pkg::SALT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        bbf_pkg::CFG_BLOCKS_LOG2: regs.blocks_log2 <= cfg.data[bbf_pkg::LOG2_W-1:0];
        bbf_pkg::CFG_SALT_0:      regs.salt[0]     <= cfg.data;
        bbf_pkg::CFG_SALT_1:      regs.salt[1]     <= cfg.data;
        bbf_pkg::CFG_SALT_2:      regs.salt[2]     <= cfg.data;
        bbf_pkg::CFG_SALT_3:      regs.salt[3]     <= cfg.data;
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  bbf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .regs       (regs),
    .enable     (!clearing),
    .req        (req),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  bbf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_data   (pop_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  bbf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_data   (pop_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .res        (res),
    .clearing   (clearing)
  );

endmodule

`default_nettype wire

@@ tb/sv/tb_blocked_bloom_filter_128bit_core.sv @@
// ----------------------------------------------------------------------------
// tb_blocked_bloom_filter_128bit_core: self-checking bench for the Bloom core
// Drives add, find and merge items through several register settings. A
// shadow copy of the block store predicts every result, and each result is
// compared against the oldest prediction. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

typedef struct {
  bbf_pkg::op_t                       op;
  logic [bbf_pkg::HASH_W-1:0]         key_hash;
  logic [bbf_pkg::WIDX_W-1:0]         word_index;
  logic [bbf_pkg::WORD_W-1:0]         word_value;
} bloom_req_t;

typedef struct {
  logic                               found;
  logic [bbf_pkg::COUNT_W-1:0]        set_bits;
  logic                               error;
} bloom_res_t;

class bloom_shadow;
  logic [bbf_pkg::WORD_W-1:0]  words [bbf_pkg::WORDS*bbf_pkg::DEPTH];
  int unsigned                 set_count;
  logic [bbf_pkg::LOG2_W-1:0]  blocks_log2;
  logic [bbf_pkg::WORD_W-1:0]  salt [bbf_pkg::WORDS];
  bloom_res_t                  expected_results[$];
  int unsigned                 mismatches;

  function new();
    foreach (words[i]) words[i] = '0;
    set_count   = 0;
    mismatches  = 0;
    blocks_log2 = bbf_pkg::BLOCKS_LOG2_RESET;
    foreach (salt[w]) salt[w] = bbf_pkg::SALT_RESET[w];
  endfunction

  function void write_reg(logic [bbf_pkg::CFG_IDX_W-1:0] idx,
                          logic [bbf_pkg::WORD_W-1:0] value);
    case (idx)
      bbf_pkg::CFG_BLOCKS_LOG2: blocks_log2 = value[bbf_pkg::LOG2_W-1:0];
      bbf_pkg::CFG_SALT_0:      salt[0] = value;
      bbf_pkg::CFG_SALT_1:      salt[1] = value;
      bbf_pkg::CFG_SALT_2:      salt[2] = value;
      bbf_pkg::CFG_SALT_3:      salt[3] = value;
      default: ;
    endcase
  endfunction

  // Oversized settings clamp to the full store.
  function int unsigned used_log2();
    return (blocks_log2 > bbf_pkg::MAX_BLOCKS_LOG2) ? bbf_pkg::MAX_BLOCKS_LOG2
                                                    : int'(blocks_log2);
  endfunction

  function logic [bbf_pkg::WORD_W-1:0] word_mask(logic [31:0] low, int w);
    logic [31:0] prod;
    prod = low * salt[w];
    return 32'd1 << prod[31:27];
  endfunction

  function void or_in(int unsigned flat, logic [bbf_pkg::WORD_W-1:0] value);
    logic [31:0] fresh;
    fresh = value & ~words[flat];
    words[flat] = words[flat] | value;
    set_count = set_count + $countones(fresh);
    if (set_count > bbf_pkg::COUNT_MAX) set_count = bbf_pkg::COUNT_MAX;
  endfunction

  function void apply_request(bloom_req_t r);
    int unsigned l;
    int unsigned base;
    logic [31:0] m;
    bloom_res_t out;
    l = used_log2();
    base = (l == 0) ? 0 : int'(r.key_hash >> (64 - l)) * bbf_pkg::WORDS;
    out.found = 1'b0;
    out.error = 1'b0;
    case (r.op)
      bbf_pkg::OP_ADD: begin
        for (int w = 0; w < bbf_pkg::WORDS; w++)
          or_in(base + w, word_mask(r.key_hash[31:0], w));
      end
      bbf_pkg::OP_FIND: begin
        out.found = 1'b1;
        for (int w = 0; w < bbf_pkg::WORDS; w++) begin
          m = word_mask(r.key_hash[31:0], w);
          if ((words[base + w] & m) != m) out.found = 1'b0;
        end
      end
      bbf_pkg::OP_MERGE: begin
        if (int'(r.word_index) < (bbf_pkg::WORDS << l)) or_in(r.word_index, r.word_value);
        else out.error = 1'b1;
      end
      default: ;
    endcase
    out.set_bits = set_count[bbf_pkg::COUNT_W-1:0];
    expected_results.push_back(out);
  endfunction

  function void check_result(bloom_res_t got);
    bloom_res_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result found=%0d set_bits=%0d error=%0d",
               $time, got.found, got.set_bits, got.error);
      return;
    end
    want = expected_results.pop_front();
    if (got.found !== want.found) begin
      mismatches++;
      $display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
    end
    if (got.set_bits !== want.set_bits) begin
      mismatches++;
      $display("%0t: set_bits expected %0d actual %0d", $time, want.set_bits, got.set_bits);
    end
    if (got.error !== want.error) begin
      mismatches++;
      $display("%0t: error expected %0d actual %0d", $time, want.error, got.error);
    end
  endfunction

  function int pending();
    return expected_results.size();
  endfunction
endclass

module tb_blocked_bloom_filter_128bit_core;
  import bbf_pkg::*;

  localparam int WATCHDOG_LIMIT = 12000;
  localparam int RANDOM_PER_PHASE = 260;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bbf_req_if req_ch ();
  bbf_res_if res_ch ();
  bbf_cfg_if cfg_ch ();

  blocked_bloom_filter_128bit_core u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  bloom_shadow sb = new();

  logic [HASH_W-1:0] added_hashes[$];
  int unsigned       sent = 0;
  bit                send_calm = 1'b0;
  int unsigned       idle_run;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic send_request(bloom_req_t r);
    int unsigned gap;
    if (sent % 40 == 0) send_calm = ($urandom_range(0, 2) == 0);
    gap = send_calm ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= r.op;
    req_ch.key_hash   <= r.key_hash;
    req_ch.word_index <= r.word_index;
    req_ch.word_value <= r.word_value;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.apply_request(r);
    sent++;
  endtask

  task automatic send(op_t op, logic [HASH_W-1:0] hash, logic [WIDX_W-1:0] idx,
                      logic [WORD_W-1:0] value);
    bloom_req_t r;
    r.op = op;
    r.key_hash = hash;
    r.word_index = idx;
    r.word_value = value;
    send_request(r);
  endtask

  // Drop valid and hold until every outstanding result is back.
  task automatic settle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.write_reg(idx, value);
  endtask

  task automatic configure(logic [LOG2_W-1:0] log2, logic [WORD_W-1:0] s0,
                           logic [WORD_W-1:0] s1, logic [WORD_W-1:0] s2,
                           logic [WORD_W-1:0] s3);
    settle();
    write_reg(CFG_BLOCKS_LOG2, {28'd0, log2});
    write_reg(CFG_SALT_0, s0);
    write_reg(CFG_SALT_1, s1);
    write_reg(CFG_SALT_2, s2);
    write_reg(CFG_SALT_3, s3);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic bloom_req_t random_request();
    bloom_req_t r;
    int unsigned pick;
    int unsigned l;
    l = sb.used_log2();
    r.op = OP_NONE;
    r.key_hash = {$urandom, $urandom};
    r.word_index = $urandom;
    r.word_value = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      r.op = OP_ADD;
      added_hashes.push_back(r.key_hash);
      if (added_hashes.size() > 48) void'(added_hashes.pop_front());
    end else if (pick < 70) begin
      r.op = OP_FIND;
      // mostly look up keys already added; flip a bit now and then for near misses
      if (added_hashes.size() > 0 && pick < 64) begin
        r.key_hash = added_hashes[$urandom_range(0, added_hashes.size() - 1)];
        if (pick >= 58) r.key_hash ^= 64'd1 << $urandom_range(0, 63);
      end
    end else if (pick < 95) begin
      r.op = OP_MERGE;
      if (pick < 92) r.word_index = $urandom_range(0, (WORDS << l) - 1);
      if (pick[0]) r.word_value = $urandom & $urandom & $urandom;
    end
    return r;
  endfunction

  task automatic run_random(int unsigned count, int unsigned pause_at);
    for (int unsigned n = 0; n < count; n++) begin
      if (n == pause_at) settle();
      send_request(random_request());
    end
  endtask

  initial begin : result_sink
    bloom_res_t  got;
    int unsigned stall;
    int unsigned taken;
    bit          calm;
    taken = 0;
    calm = 1'b0;
    res_ch.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (taken % 40 == 0) calm = ($urandom_range(0, 2) == 0);
      stall = calm ? 0 : $urandom_range(0, 16);
      // one long hold so the engine and queue back up into the request side
      if (taken == 600) stall = 400;
      @(negedge clk);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (res_ch.valid !== 1'b1);
      got.found    = res_ch.found;
      got.set_bits = res_ch.set_bits;
      got.error    = res_ch.error;
      sb.check_result(got);
      taken++;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_run <= 0;
    end else if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
      if (idle_run >= WATCHDOG_LIMIT) begin
        $display("FAIL blocked_bloom_filter_128bit_core");
        $finish;
      end
    end
  end

  initial begin : stimulus
    req_ch.valid      = 1'b0;
    req_ch.req_type   = '0;
    req_ch.key_hash   = '0;
    req_ch.word_index = '0;
    req_ch.word_value = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = '0;
    cfg_ch.data       = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset register values, full store
    send(OP_ADD,   64'd0, '0, '0);
    send(OP_FIND,  64'd0, '0, '0);
    send(OP_ADD,   '1, '0, '0);
    send(OP_FIND,  '1, '0, '0);
    send(OP_FIND,  64'h0123_4567_89ab_cdef, '0, '0);
    send(OP_MERGE, 64'd0, 14'd0, 32'hffff_ffff);
    send(OP_MERGE, 64'd0, 14'h3fff, 32'h8000_0001);
    send(OP_MERGE, 64'd0, 14'h3fff, 32'hffff_ffff);
    send(OP_NONE,  '1, '1, '1);
    send(OP_FIND,  64'h8000_0000_0000_0000, '0, '0);
    send(OP_ADD,   64'hfff0_0000_0000_0000, '0, '0);
    run_random(RANDOM_PER_PHASE, RANDOM_PER_PHASE);

    // single block, degenerate salts
    configure(4'd0, 32'd0, 32'hffff_ffff, $urandom, $urandom);
    send(OP_ADD,   {$urandom, $urandom}, '0, '0);
    send(OP_FIND,  {$urandom, $urandom}, '0, '0);
    send(OP_MERGE, 64'd0, 14'd3, 32'h0000_0001);
    send(OP_MERGE, 64'd0, 14'd4, 32'hffff_ffff);
    send(OP_MERGE, 64'd0, 14'h3fff, 32'hffff_ffff);
    send(OP_NONE,  64'd0, '0, '0);
    run_random(RANDOM_PER_PHASE, RANDOM_PER_PHASE);

    // oversized block count clamps to the full store
    configure(4'd15, $urandom, $urandom, $urandom, $urandom);
    send(OP_MERGE, 64'd0, 14'h3fff, 32'h5555_5555);
    send(OP_ADD,   '1, '0, '0);
    send(OP_FIND,  '1, '0, '0);
    run_random(RANDOM_PER_PHASE, RANDOM_PER_PHASE);

    configure(4'd3, $urandom, $urandom, $urandom, $urandom);
    run_random(RANDOM_PER_PHASE, RANDOM_PER_PHASE / 2);

    configure(4'd12, 32'hffff_ffff, 32'd1, 32'h8000_0000, 32'd0);
    run_random(RANDOM_PER_PHASE, RANDOM_PER_PHASE);

    configure(4'd1, $urandom, $urandom, $urandom, $urandom);
    run_random(RANDOM_PER_PHASE, RANDOM_PER_PHASE);

    configure(4'd7, SALT_RESET[0], SALT_RESET[1], SALT_RESET[2], SALT_RESET[3]);
    run_random(RANDOM_PER_PHASE, RANDOM_PER_PHASE);

    settle();
    repeat (16) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("PASS blocked_bloom_filter_128bit_core");
    end else begin
      $display("FAIL blocked_bloom_filter_128bit_core");
    end
    $finish;
  end

endmodule
